### hdl/lcm_pkg.sv
// lcm_pkg: shared types and constants for the Life cell map engine.
// Depends on nothing; used by the controller, the datapath and the top level.
package lcm_pkg;

    localparam logic [2:0] MODE_SET  = 3'd0;
    localparam logic [2:0] MODE_CLR  = 3'd1;
    localparam logic [2:0] MODE_STEP = 3'd2;
    localparam logic [2:0] MODE_READ = 3'd3;
    localparam logic [2:0] MODE_WIPE = 3'd4;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam logic [8:0] DIM_RESET = 9'd256;
    localparam logic [8:0] DIM_MIN   = 9'd3;

    localparam logic [3:0] CNT_TWO   = 4'd2;
    localparam logic [3:0] CNT_THREE = 4'd3;

    // neighbor offset selects
    localparam logic [1:0] SEL_M = 2'd0;
    localparam logic [1:0] SEL_Z = 2'd1;
    localparam logic [1:0] SEL_P = 2'd2;

    localparam logic [1:0] NB_DC [8] = '{SEL_M, SEL_Z, SEL_P, SEL_M, SEL_P, SEL_M, SEL_Z, SEL_P};
    localparam logic [1:0] NB_DR [8] = '{SEL_M, SEL_M, SEL_M, SEL_Z, SEL_Z, SEL_P, SEL_P, SEL_P};

    typedef enum logic [2:0] {
        OP_SET,
        OP_CLR,
        OP_STEP,
        OP_READ,
        OP_WIPE
    } t_op;

    typedef struct packed {
        logic acc;
        logic ctr_rd;
        logic ctr_wr;
        logic nb_rd;
        logic nb_wr;
        logic sw_zero;
        logic sw_adv;
        logic cpy_rd;
        logic snap_rd;
        logic walk_load;
        logic clr_zero;
        logic clr_wr;
        logic res_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  in_op;
        logic ctr_need;
        logic snap_change;
        logic sw_last;
        logic clr_last;
        logic nb_last;
        logic out_free;
    } t_sts;

endpackage

### hdl/lcm_ifs.sv
// lcm_ifs: valid/ready channel interfaces for commands, results and config.
// Depends on nothing.
interface lcm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] col;
    logic [7:0] row;
    modport source (output valid, mode, col, row, input ready);
    modport sink (input valid, mode, col, row, output ready);
endinterface

interface lcm_res_if;
    logic        valid;
    logic        ready;
    logic        alive;
    logic [3:0]  neighbor_count;
    logic [31:0] generation;
    modport source (output valid, alive, neighbor_count, generation, input ready);
    modport sink (input valid, alive, neighbor_count, generation, output ready);
endinterface

interface lcm_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/lcm_ctrl.sv
// lcm_ctrl: sequencing state machine for the Life cell map engine.
// Depends on lcm_pkg; drives lcm_dp through t_cmd and reads t_sts.
module lcm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lcm_pkg::t_sts i_sts,
    output lcm_pkg::t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_CLR  = 12'b000000000001,
        S_IDLE = 12'b000000000010,
        S_CRD  = 12'b000000000100,
        S_CDEC = 12'b000000001000,
        S_NRD  = 12'b000000010000,
        S_NWR  = 12'b000000100000,
        S_CPY  = 12'b000001000000,
        S_CEND = 12'b000010000000,
        S_WRD  = 12'b000100000000,
        S_WDEC = 12'b001000000000,
        S_RRD  = 12'b010000000000,
        S_ROUT = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_walk, n_walk;
    logic   r_init, n_init;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_walk  = r_walk;
        n_init  = r_init;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_init ? S_IDLE : S_RRD;
                    n_init  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    case (i_sts.in_op)
                        lcm_pkg::OP_SET, lcm_pkg::OP_CLR: n_state = S_CRD;
                        lcm_pkg::OP_STEP: begin
                            o_cmd.sw_zero = 1'b1;
                            n_state = S_CPY;
                        end
                        lcm_pkg::OP_WIPE: begin
                            o_cmd.clr_zero = 1'b1;
                            n_state = S_CLR;
                        end
                        default: n_state = S_RRD;
                    endcase
                end
            end
            S_CRD: begin
                o_cmd.ctr_rd = 1'b1;
                n_state = S_CDEC;
            end
            S_CDEC: begin
                if (i_sts.ctr_need) begin
                    o_cmd.ctr_wr = 1'b1;
                    n_state = S_NRD;
                end else if (r_walk) begin
                    if (i_sts.sw_last) begin
                        n_walk  = 1'b0;
                        n_state = S_RRD;
                    end else begin
                        o_cmd.sw_adv = 1'b1;
                        n_state = S_WRD;
                    end
                end else begin
                    n_state = S_RRD;
                end
            end
            S_NRD: begin
                o_cmd.nb_rd = 1'b1;
                n_state = S_NWR;
            end
            S_NWR: begin
                o_cmd.nb_wr = 1'b1;
                if (!i_sts.nb_last) begin
                    n_state = S_NRD;
                end else if (r_walk) begin
                    if (i_sts.sw_last) begin
                        n_walk  = 1'b0;
                        n_state = S_RRD;
                    end else begin
                        o_cmd.sw_adv = 1'b1;
                        n_state = S_WRD;
                    end
                end else begin
                    n_state = S_RRD;
                end
            end
            S_CPY: begin
                o_cmd.cpy_rd = 1'b1;
                o_cmd.sw_adv = 1'b1;
                if (i_sts.sw_last) n_state = S_CEND;
            end
            S_CEND: begin
                o_cmd.sw_zero = 1'b1;
                n_walk  = 1'b1;
                n_state = S_WRD;
            end
            S_WRD: begin
                o_cmd.snap_rd = 1'b1;
                n_state = S_WDEC;
            end
            S_WDEC: begin
                if (i_sts.snap_change) begin
                    o_cmd.walk_load = 1'b1;
                    n_state = S_CRD;
                end else if (i_sts.sw_last) begin
                    n_walk  = 1'b0;
                    n_state = S_RRD;
                end else begin
                    o_cmd.sw_adv = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_RRD: begin
                o_cmd.res_rd = 1'b1;
                n_state = S_ROUT;
            end
            S_ROUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_walk  <= 1'b0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            r_init  <= n_init;
        end
    end

endmodule

### hdl/lcm_dp.sv
// lcm_dp: cell map and snapshot memories, coordinate and sweep registers,
// generation count, config registers and result register. Depends on lcm_pkg.
module lcm_dp #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lcm_pkg::t_cmd i_cmd,
    output lcm_pkg::t_sts o_sts,
    input  logic [2:0]    i_mode,
    input  logic [7:0]    i_col,
    input  logic [7:0]    i_row,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [8:0]    i_cfg_data,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic          o_alive,
    output logic [3:0]    o_neighbor_count,
    output logic [31:0]   o_generation
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [8:0] clamp_dim(input logic [8:0] v, input int maxv);
        logic [8:0] res;
        if (v < lcm_pkg::DIM_MIN) res = lcm_pkg::DIM_MIN;
        else if (32'(v) > maxv) res = 9'(maxv);
        else res = v;
        return res;
    endfunction

    function automatic logic [AW-1:0] idx(input logic [8:0] c, input logic [8:0] r);
        return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
    endfunction

    logic [4:0] r_cells [DEPTH];
    logic [4:0] r_snap [DEPTH];

    logic [8:0]    r_cols, r_rows;
    logic [8:0]    r_col, r_row;
    logic          r_inside;
    logic [8:0]    r_cc, r_cr;
    logic          r_up;
    logic [2:0]    r_nb;
    logic [8:0]    r_sc, r_sr;
    logic [AW-1:0] r_clr;
    logic [4:0]    r_cq, r_sq;
    logic          r_cpend;
    logic [AW-1:0] r_cpa;
    logic [31:0]   r_gen;
    logic          r_ov;
    logic          r_oalive;
    logic [3:0]    r_ocnt;
    logic [31:0]   r_ogen;

    logic          in_inside;
    lcm_pkg::t_op  in_op;
    logic [8:0]    cm1, cp1, rm1, rp1, nbc, nbr;
    logic [9:0]    cinc, rinc;
    logic [AW-1:0] ctr_a, nb_a, sw_a, op_a;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_a, wr_a;
    logic [4:0]    wr_d;

    assign in_inside = ({1'b0, i_col} < r_cols) && ({1'b0, i_row} < r_rows);

    always_comb begin
        case (i_mode)
            lcm_pkg::MODE_SET:  in_op = in_inside ? lcm_pkg::OP_SET : lcm_pkg::OP_READ;
            lcm_pkg::MODE_CLR:  in_op = in_inside ? lcm_pkg::OP_CLR : lcm_pkg::OP_READ;
            lcm_pkg::MODE_STEP: in_op = lcm_pkg::OP_STEP;
            lcm_pkg::MODE_WIPE: in_op = lcm_pkg::OP_WIPE;
            default:            in_op = lcm_pkg::OP_READ;
        endcase
    end

    assign o_sts.in_op = in_op;

    assign cinc = {1'b0, r_cc} + 10'd1;
    assign rinc = {1'b0, r_cr} + 10'd1;
    assign cm1  = (r_cc == 9'd0) ? r_cols - 9'd1 : r_cc - 9'd1;
    assign rm1  = (r_cr == 9'd0) ? r_rows - 9'd1 : r_cr - 9'd1;
    assign cp1  = (cinc >= {1'b0, r_cols}) ? 9'd0 : cinc[8:0];
    assign rp1  = (rinc >= {1'b0, r_rows}) ? 9'd0 : rinc[8:0];

    always_comb begin
        case (lcm_pkg::NB_DC[r_nb])
            lcm_pkg::SEL_M: nbc = cm1;
            lcm_pkg::SEL_P: nbc = cp1;
            default:        nbc = r_cc;
        endcase
        case (lcm_pkg::NB_DR[r_nb])
            lcm_pkg::SEL_M: nbr = rm1;
            lcm_pkg::SEL_P: nbr = rp1;
            default:        nbr = r_cr;
        endcase
    end

    assign ctr_a = idx(r_cc, r_cr);
    assign nb_a  = idx(nbc, nbr);
    assign sw_a  = idx(r_sc, r_sr);
    assign op_a  = idx(r_col, r_row);

    always_comb begin
        rd_en = 1'b1;
        rd_a  = ctr_a;
        if (i_cmd.nb_rd) rd_a = nb_a;
        else if (i_cmd.cpy_rd) rd_a = sw_a;
        else if (i_cmd.res_rd) begin
            rd_a  = op_a;
            rd_en = r_inside;
        end else if (!i_cmd.ctr_rd) rd_en = 1'b0;

        wr_en = i_cmd.ctr_wr | i_cmd.nb_wr | i_cmd.clr_wr;
        wr_a  = ctr_a;
        wr_d  = {r_cq[4:1], r_up};
        if (i_cmd.nb_wr) begin
            wr_a = nb_a;
            wr_d = {r_up ? r_cq[4:1] + 4'd1 : r_cq[4:1] - 4'd1, r_cq[0]};
        end else if (i_cmd.clr_wr) begin
            wr_a = r_clr;
            wr_d = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_cells[wr_a] <= wr_d;
        if (rd_en) r_cq <= r_cells[rd_a];
        if (r_cpend) r_snap[r_cpa] <= r_cq;
        if (i_cmd.snap_rd) r_sq <= r_snap[sw_a];
    end

    assign o_sts.ctr_need    = r_up ? !r_cq[0] : r_cq[0];
    assign o_sts.snap_change = r_sq[0]
        ? (r_sq[4:1] != lcm_pkg::CNT_TWO && r_sq[4:1] != lcm_pkg::CNT_THREE)
        : (r_sq[4:1] == lcm_pkg::CNT_THREE);
    assign o_sts.sw_last  = (r_sc == r_cols - 9'd1) && (r_sr == r_rows - 9'd1);
    assign o_sts.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_sts.nb_last  = (r_nb == 3'd7);
    assign o_sts.out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        r_cpa <= sw_a;
        if (i_cmd.acc) begin
            r_col    <= {1'b0, i_col};
            r_row    <= {1'b0, i_row};
            r_inside <= in_inside;
            r_cc     <= {1'b0, i_col};
            r_cr     <= {1'b0, i_row};
            r_up     <= (i_mode == lcm_pkg::MODE_SET);
        end else if (i_cmd.walk_load) begin
            r_cc <= r_sc;
            r_cr <= r_sr;
            r_up <= !r_sq[0];
        end
        if (i_cmd.out_load) begin
            r_oalive <= r_inside & r_cq[0];
            r_ocnt   <= r_inside ? r_cq[4:1] : 4'd0;
            r_ogen   <= r_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= clamp_dim(lcm_pkg::DIM_RESET, MAX_COLS);
            r_rows  <= clamp_dim(lcm_pkg::DIM_RESET, MAX_ROWS);
            r_nb    <= 3'd0;
            r_sc    <= 9'd0;
            r_sr    <= 9'd0;
            r_clr   <= '0;
            r_cpend <= 1'b0;
            r_gen   <= 32'd0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == lcm_pkg::CFG_COLS) r_cols <= clamp_dim(i_cfg_data, MAX_COLS);
                else r_rows <= clamp_dim(i_cfg_data, MAX_ROWS);
            end
            if (i_cmd.ctr_wr) r_nb <= 3'd0;
            else if (i_cmd.nb_wr) r_nb <= r_nb + 3'd1;
            if (i_cmd.sw_zero) begin
                r_sc <= 9'd0;
                r_sr <= 9'd0;
            end else if (i_cmd.sw_adv) begin
                if (r_sc == r_cols - 9'd1) begin
                    r_sc <= 9'd0;
                    r_sr <= r_sr + 9'd1;
                end else begin
                    r_sc <= r_sc + 9'd1;
                end
            end
            if (i_cmd.clr_zero) r_clr <= '0;
            else if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);
            r_cpend <= i_cmd.cpy_rd;
            if (i_cmd.acc && in_op == lcm_pkg::OP_STEP) r_gen <= r_gen + 32'd1;
            if (i_cmd.out_load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_alive          = r_oalive;
    assign o_neighbor_count = r_ocnt;
    assign o_generation     = r_ogen;

endmodule

### hdl/life_cell_map_engine.sv
// Life cell map engine top level: toroidal Life map with per-cell neighbor counts.
// Work per item: a read looks up one cell; a set/clear does up to nine read-modify-writes
// (the cell and its eight neighbors) on the cell map RAM; a step copies the map to the
// snapshot, walks every cell and updates each changed cell; a clear map zeroes all cells.
// One item at a time; the next beat is taken the cycle after the result is loaded.
// Reset: synchronous; all MAX_ROWS*MAX_COLS cells are cleared before the first beat.
module life_cell_map_engine #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lcm_cmd_if.sink   i_cmd,
    lcm_res_if.source o_res,
    lcm_cfg_if.sink   i_cfg
);

    lcm_pkg::t_cmd cmd;
    lcm_pkg::t_sts sts;
    logic          in_ready;

    assign i_cmd.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    lcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lcm_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_cmd.mode),
        .i_col            (i_cmd.col),
        .i_row            (i_cmd.row),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_alive          (o_res.alive),
        .o_neighbor_count (o_res.neighbor_count),
        .o_generation     (o_res.generation)
    );

endmodule
